### rtl/core/ipsc_pkg.sv
// ----------------------------------------------------------------------------
// ipsc_pkg
// Shared types, widths and constants for the IR pulse/space capture core.
// ----------------------------------------------------------------------------
package ipsc_pkg;

	localparam int HZ_W   = 20;   // timer_hz register
	localparam int DLY_W  = 10;   // sensor_delay_us register
	localparam int CNT_W  = 17;   // timer edge count
	localparam int DUR_W  = 24;   // duration_us field
	localparam int MUL_W  = 20;   // microseconds per second fits here
	localparam int PROD_W = CNT_W + MUL_W;
	localparam int DIV_CNT_W = $clog2(PROD_W + 1);
	localparam int CFG_ADDR_W = 1;
	localparam int IN_TDATA_W = 8;

	localparam int SPACE_LIMIT_DEF = 15;

	localparam logic [MUL_W-1:0] USEC_PER_SEC = MUL_W'(1000000);
	localparam logic [DUR_W-1:0] DUR_MAX      = {DUR_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
	localparam logic [HZ_W-1:0]  HZ_RESET     = HZ_W'(65536);

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_TIMER_HZ     = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_DELAY = 1'b1;

	typedef enum logic [1:0] {
		ST_RUN,   // taking pin samples
		ST_DIV,   // pulse length conversion in progress
		ST_PUT    // converted pulse waits for the output slot
	} state_t;

endpackage

### rtl/core/ipsc_divider.sv
// ----------------------------------------------------------------------------
// ipsc_divider
// Bit-serial restoring divider: edge_count * 1e6 / timer_hz, one quotient
// bit per cycle. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module ipsc_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ipsc_pkg::CNT_W-1:0] count,
	input  logic [ipsc_pkg::HZ_W-1:0]  divisor,
	output logic                       done,
	output logic [ipsc_pkg::PROD_W-1:0] quotient
);
	import ipsc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [PROD_W-1:0]    num_q;     // dividend shifts out, quotient shifts in
	logic [HZ_W-1:0]      rem_q;
	logic [HZ_W-1:0]      den_q;
	logic                 den_zero_q;
	logic [HZ_W:0]        trial;
	logic                 qbit;

	assign trial = {rem_q, num_q[PROD_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == DIV_CNT_W'(PROD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q      <= PROD_W'(count) * PROD_W'(USEC_PER_SEC);
			rem_q      <= '0;
			den_q      <= divisor;
			den_zero_q <= (divisor == '0);
		end else if (busy_q) begin
			rem_q <= qbit ? HZ_W'(trial - {1'b0, den_q}) : trial[HZ_W-1:0];
			num_q <= {num_q[PROD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = den_zero_q ? '0 : num_q;

endmodule

### rtl/core/ir_pulse_space_capture_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_space_capture_core
// IR receiver pulse/space timing capture with bit-serial length conversion.
// ----------------------------------------------------------------------------
// One pin-sample word (timer, IR, deselect, microsecond tick) is taken per
// clock. A space word leaves on the output register the cycle after the
// sample that starts a pulse. The sample that ends a pulse closes the input
// while the pulse length (edge_count * 1e6 / timer_hz) comes out of a
// bit-serial divider at one quotient bit per cycle and, with the delay
// removed, is written into the output register. Input also pauses while
// an output word is held back by the sink.
module ir_pulse_space_capture_core #(
	parameter int SPACE_LIMIT_SECONDS = ipsc_pkg::SPACE_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ipsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ipsc_pkg::HZ_W-1:0]       cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [0] timer_level, [1] ir_level, [2] port_deselected, [3] usec_tick, rest 0
	input  logic [ipsc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [23:0] duration_us
	output logic [ipsc_pkg::DUR_W-1:0]      m_axis_tdata,
	// [0] is_pulse
	output logic [0:0]                      m_axis_tuser
);
	import ipsc_pkg::*;

	localparam logic [DUR_W:0] SPACE_LIMIT = (DUR_W+1)'((SPACE_LIMIT_SECONDS + 1) * 1000000);

	logic [HZ_W-1:0]  timer_hz_q;
	logic [DLY_W-1:0] delay_q;

	logic             prev_tl_q;
	logic             active_q;
	logic             wfl_q;
	logic [CNT_W-1:0] ec_q;
	logic [DUR_W-1:0] space_q;
	logic             seen_q;

	logic             out_valid_q;
	logic             out_pulse_q;
	logic [DUR_W-1:0] out_dur_q;

	state_t state_q, state_d;

	logic tl, ir, desel, tick;
	logic acc, slot_free, put_fire;
	logic rising, timeout;
	logic [CNT_W-1:0] ec_inc;
	logic [DUR_W-1:0] space_inc;
	logic [HZ_W:0]    ec_x10;
	logic n_active, n_wfl, n_seen, emit_space, pulse_end;
	logic [CNT_W-1:0] n_ec;
	logic [DUR_W-1:0] n_space;
	logic [DUR_W:0]   space_sum;
	logic [DUR_W-1:0] space_dur;
	logic             div_done;
	logic [PROD_W-1:0] div_quot;
	logic [PROD_W-1:0] pulse_len;
	logic [DUR_W-1:0]  pulse_dur;

	assign tl    = s_axis_tdata[0];
	assign ir    = s_axis_tdata[1];
	assign desel = s_axis_tdata[2];
	assign tick  = s_axis_tdata[3];

	assign slot_free = !out_valid_q || m_axis_tready;
	assign acc       = s_axis_tvalid && s_axis_tready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_hz_q <= HZ_RESET;
			delay_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TIMER_HZ:     timer_hz_q <= cfg_wdata;
				REG_SENSOR_DELAY: delay_q    <= cfg_wdata[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	// per-sample tracking
	always_comb begin
		rising    = !prev_tl_q && tl;
		ec_inc    = (rising && ec_q != CNT_MAX) ? ec_q + 1'b1 : ec_q;
		// edge_count > timer_hz/10  <=>  10*edge_count > timer_hz
		ec_x10    = {1'b0, ec_inc, 3'b000} + {3'b000, ec_inc, 1'b0};
		timeout   = ec_x10 > {1'b0, timer_hz_q};
		space_inc = (tick && space_q != DUR_MAX) ? space_q + 1'b1 : space_q;

		n_active   = active_q;
		n_wfl      = wfl_q;
		n_ec       = ec_q;
		n_space    = space_q;
		n_seen     = seen_q;
		emit_space = 1'b0;
		pulse_end  = 1'b0;

		if (active_q) begin
			n_ec = ec_inc;
			if (timeout || desel) begin
				n_active = 1'b0;
				n_wfl    = 1'b1;
				n_space  = '0;
			end else if (!ir) begin
				pulse_end = 1'b1;
				n_active  = 1'b0;
				n_wfl     = 1'b0;
				n_space   = '0;
			end
		end else if (ir && !wfl_q && !desel) begin
			emit_space = seen_q;
			n_seen     = 1'b1;
			n_active   = 1'b1;
			n_wfl      = 1'b1;
			n_ec       = CNT_W'(1);
		end else begin
			if (!ir)
				n_wfl = 1'b0;
			else if (desel)
				n_wfl = 1'b1;
			n_space = space_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tl_q <= 1'b0;
			active_q  <= 1'b0;
			wfl_q     <= 1'b0;
			ec_q      <= '0;
			space_q   <= '0;
			seen_q    <= 1'b0;
		end else if (acc) begin
			prev_tl_q <= tl;
			active_q  <= n_active;
			wfl_q     <= n_wfl;
			ec_q      <= n_ec;
			space_q   <= n_space;
			seen_q    <= n_seen;
		end
	end

	// space word: at least the limit reads as very long, else saturating add
	always_comb begin
		space_sum = {1'b0, space_q} + (DUR_W+1)'(delay_q);
		if ({1'b0, space_q} >= SPACE_LIMIT || space_sum > {1'b0, DUR_MAX})
			space_dur = DUR_MAX;
		else
			space_dur = space_sum[DUR_W-1:0];
	end

	ipsc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (acc && pulse_end),
		.count    (n_ec),
		.divisor  (timer_hz_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// pulse word: remove delay with a floor of one, clamp to field
	always_comb begin
		if (div_quot > PROD_W'(delay_q))
			pulse_len = div_quot - PROD_W'(delay_q);
		else
			pulse_len = PROD_W'(1);
		pulse_dur = (pulse_len > PROD_W'(DUR_MAX)) ? DUR_MAX : pulse_len[DUR_W-1:0];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: if (acc && pulse_end) state_d = ST_DIV;
			ST_DIV: if (div_done)         state_d = ST_PUT;
			ST_PUT: if (slot_free)        state_d = ST_RUN;
			default:                      state_d = ST_RUN;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		put_fire      = 1'b0;
		unique case (state_q)
			ST_RUN: s_axis_tready = slot_free;
			ST_DIV: ;
			ST_PUT: put_fire = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RUN;
		else
			state_q <= state_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((acc && emit_space) || put_fire)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc && emit_space) begin
			out_pulse_q <= 1'b0;
			out_dur_q   <= space_dur;
		end else if (put_fire) begin
			out_pulse_q <= 1'b1;
			out_dur_q   <= pulse_dur;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_dur_q;
	assign m_axis_tuser[0] = out_pulse_q;

endmodule

### rtl/core/ipsc_checker.sv
// ----------------------------------------------------------------------------
// ipsc_checker
// Port-level checks for the IR pulse/space capture core.
// ----------------------------------------------------------------------------
module ipsc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [ipsc_pkg::DUR_W-1:0]      m_axis_tdata,
	input logic [0:0]                      m_axis_tuser
);
	import ipsc_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// a blocked output slot closes the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input open while output slot is full");

	// pulse lengths are floored at one microsecond
	a_pulse_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != '0)
		else $error("zero-length pulse word");

endmodule

bind ir_pulse_space_capture_core ipsc_checker u_ipsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### verif/tb_ir_pulse_space_capture_core.sv
// ----------------------------------------------------------------------------
// tb_ir_pulse_space_capture_core
// Self-checking bench for the IR pulse/space capture core. A tracker class
// mirrors the pulse/space timing state and predicts each duration word.
// Pin-sample words are driven as pulse/space sequences with random content,
// plus noise. Both stream sides idle at random. Config is changed between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_ir_pulse_space_capture_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ipsc_pkg::*;

	// space limit of one second for the core
	localparam int SPACE_SECS = 1;

	typedef struct packed {
		logic             is_pulse;
		logic [DUR_W-1:0] dur;
	} duration_t;

	class capture_tracker;
		logic [HZ_W-1:0]  hz;
		logic [DLY_W-1:0] dly;
		bit               prev_tmr;
		bit               in_pulse;
		bit               hold_low;
		bit               seen_pulse;
		logic [CNT_W-1:0] edges;
		logic [DUR_W-1:0] space_us;
		duration_t        durations_due[$];
		int               errors;

		function new();
			hz = HZ_RESET;
			dly = '0;
			prev_tmr = 0;
			in_pulse = 0;
			hold_low = 0;
			seen_pulse = 0;
			edges = '0;
			space_us = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [HZ_W-1:0] val);
			if (idx == REG_TIMER_HZ)
				hz = val;
			else if (idx == REG_SENSOR_DELAY)
				dly = val[DLY_W-1:0];
		endfunction

		function logic [DUR_W-1:0] space_len();
			longint v;
			if (longint'(space_us) >= longint'(SPACE_SECS + 1) * longint'(USEC_PER_SEC))
				return DUR_MAX;
			v = longint'(space_us) + longint'(dly);
			if (v > longint'(DUR_MAX))
				v = longint'(DUR_MAX);
			return v[DUR_W-1:0];
		endfunction

		function logic [DUR_W-1:0] pulse_len();
			longint v;
			v = 0;
			if (hz != 0)
				v = (longint'(edges) * longint'(USEC_PER_SEC)) / longint'(hz);
			if (v > longint'(dly))
				v = v - longint'(dly);
			else
				v = 1;
			if (v > longint'(DUR_MAX))
				v = longint'(DUR_MAX);
			return v[DUR_W-1:0];
		endfunction

		function void take_sample(logic [IN_TDATA_W-1:0] w);
			bit tl;
			bit ir;
			bit ds;
			bit tk;
			bit rise;
			tl = w[0];
			ir = w[1];
			ds = w[2];
			tk = w[3];
			rise = !prev_tmr && tl;
			prev_tmr = tl;
			if (in_pulse) begin
				if (rise && edges != CNT_MAX)
					edges++;
				if (edges > hz / 10 || ds) begin
					// dropped pulse: no word
					in_pulse = 0;
					hold_low = 1;
					space_us = '0;
				end else if (!ir) begin
					durations_due.push_back('{is_pulse: 1'b1, dur: pulse_len()});
					in_pulse = 0;
					hold_low = 0;
					space_us = '0;
				end
				return;
			end
			if (!ir) begin
				hold_low = 0;
			end else if (!hold_low) begin
				if (ds) begin
					hold_low = 1;
				end else begin
					if (seen_pulse)
						durations_due.push_back('{is_pulse: 1'b0, dur: space_len()});
					seen_pulse = 1;
					in_pulse = 1;
					hold_low = 1;
					edges = 1;
					return;
				end
			end
			if (tk && space_us != DUR_MAX)
				space_us++;
		endfunction

		function void check_word(logic is_pulse, logic [DUR_W-1:0] dur);
			duration_t want;
			if (durations_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got is_pulse=%0d duration_us=%0d",
					$time, is_pulse, dur);
				return;
			end
			want = durations_due.pop_front();
			if (want.is_pulse !== is_pulse) begin
				errors++;
				$display("%0t: is_pulse expected %0d, got %0d", $time, want.is_pulse, is_pulse);
			end
			if (want.dur !== dur) begin
				errors++;
				$display("%0t: duration_us expected %0d, got %0d", $time, want.dur, dur);
			end
		endfunction

		function int pending();
			return durations_due.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [HZ_W-1:0]       cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [0] timer_level, [1] ir_level, [2] port_deselected, [3] usec_tick, rest 0
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [23:0] duration_us
	logic [DUR_W-1:0]      m_axis_tdata;
	// [0] is_pulse
	logic [0:0]            m_axis_tuser;

	capture_tracker tracker;
	bit                    quiet = 1'b0;
	bit                    tmr = 1'b0;
	int unsigned           words_sent = 0;
	int unsigned           sink_hold = 0;

	ir_pulse_space_capture_core #(
		.SPACE_LIMIT_SECONDS(SPACE_SECS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output word checked before the input word of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_word(m_axis_tuser[0], m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_sample(s_axis_tdata);
		end
	end

	// sink: random stall after each word
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sink_hold = quiet ? 0 : $urandom_range(0, 14);
		else if (sink_hold != 0)
			sink_hold--;
		m_axis_tready <= (sink_hold == 0);
	end

	function automatic logic [IN_TDATA_W-1:0] pins(bit tl, bit ir, bit ds, bit tk);
		return {{(IN_TDATA_W - 4){1'b0}}, tk, ds, ir, tl};
	endfunction

	task automatic send_word(input logic [IN_TDATA_W-1:0] w);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// hold input until every expected word is out, then let the divider finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (45)
			@(posedge clk);
	endtask

	task automatic set_regs(input logic [HZ_W-1:0] hz, input logic [HZ_W-1:0] dly);
		cfg_we <= 1'b1;
		cfg_addr <= REG_TIMER_HZ;
		cfg_wdata <= hz;
		@(posedge clk);
		tracker.set_reg(REG_TIMER_HZ, hz);
		cfg_addr <= REG_SENSOR_DELAY;
		cfg_wdata <= dly;
		@(posedge clk);
		tracker.set_reg(REG_SENSOR_DELAY, dly);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned ph;
		int unsigned phase_end;
		int unsigned n;
		int unsigned i;
		logic [HZ_W-1:0] hz;
		logic [HZ_W-1:0] dly;
		logic [IN_TDATA_W-1:0] w;

		tracker = new();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// IR already high out of reset: first pulse, no space word
		send_word(pins(0, 1, 0, 0));
		send_word(pins(1, 1, 0, 1));
		send_word(pins(0, 1, 0, 0));
		send_word(pins(1, 1, 0, 0));
		send_word(pins(1, 0, 0, 1));
		send_word(pins(0, 0, 0, 1));
		send_word(pins(0, 0, 0, 1));
		// rising IR while deselected is ignored until IR drops
		send_word(pins(0, 1, 1, 1));
		send_word(pins(1, 1, 0, 1));
		send_word(pins(0, 0, 0, 1));
		send_word(pins(1, 1, 0, 0));
		// deselect mid-pulse drops it; still-high IR does not restart
		send_word(pins(0, 1, 1, 0));
		send_word(pins(1, 1, 0, 1));
		send_word(pins(0, 0, 0, 1));
		// timer edge on the start sample is not counted
		send_word(pins(1, 1, 0, 1));
		send_word(pins(1, 0, 0, 0));
		settle();

		// max delay: pulse floors at 1, space gains the delay
		set_regs(1000000, 1023);
		send_word(pins(0, 1, 0, 0));
		send_word(pins(1, 0, 0, 1));
		// zero and sub-ten timer rates: timeout 0, pulse always dropped
		settle();
		set_regs(0, 0);
		send_word(pins(0, 1, 0, 0));
		send_word(pins(1, 1, 0, 0));
		send_word(pins(0, 0, 0, 0));
		settle();
		set_regs(9, 1);
		send_word(pins(0, 1, 0, 0));
		send_word(pins(0, 0, 0, 0));
		settle();

		// longer space of ticks, max delay added on top
		set_regs(65536, 1023);
		quiet = 1'b1;
		repeat (40)
			send_word(pins(0, 0, 0, 1));
		send_word(pins(0, 1, 0, 0));
		send_word(pins(0, 0, 0, 0));
		quiet = 1'b0;
		settle();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin hz = HZ_RESET; dly = 0; end
				1: begin hz = 1000000; dly = 1023; end
				2: begin hz = 10; dly = HZ_W'($urandom_range(0, 1023)); end
				3: begin hz = 1; dly = 0; end
				4: begin
					hz = HZ_W'($urandom_range(11, 300));
					dly = HZ_W'($urandom_range(0, 1023));
				end
				default: begin
					hz = HZ_W'($urandom_range(1000, 1000000));
					dly = HZ_W'($urandom_range(0, 60));
				end
			endcase
			set_regs(hz, dly);
			phase_end = words_sent + 220;
			while (words_sent < phase_end) begin
				quiet = ($urandom_range(0, 5) == 0);
				if ($urandom_range(0, 4) != 0) begin
					// pulse with random timer activity, then a space
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
					for (i = 0; i < n; i++) begin
						if ($urandom_range(0, 1))
							tmr = !tmr;
						send_word(pins(tmr, 1, $urandom_range(0, 39) == 0,
							1'($urandom_range(0, 1))));
					end
					n = $urandom_range(1, 10);
					for (i = 0; i < n; i++) begin
						if ($urandom_range(0, 1))
							tmr = !tmr;
						send_word(pins(tmr, 0, $urandom_range(0, 7) == 0,
							1'($urandom_range(0, 1))));
					end
				end else begin
					n = $urandom_range(1, 8);
					for (i = 0; i < n; i++) begin
						w = pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
						tmr = w[0];
						send_word(w);
					end
				end
			end
			quiet = 1'b0;
			settle();
		end

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("ir_pulse_space_capture_core: match");
		else
			$display("ir_pulse_space_capture_core: mismatch");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("ir_pulse_space_capture_core: mismatch");
		$finish;
	end

endmodule
